>>> rtl/uvt_pkg.sv
// Shared widths, codes and defaults for the unordered value table.
package uvt_pkg;

    // Field widths of the ports
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int FILL_W   = 7;
    localparam int CAP_W    = 7;

    // Table geometry defaults
    localparam int DEPTH_DEFAULT = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

endpackage

>>> rtl/uvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module uvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/uvt_ctrl.sv
// Command sequencer: appends, scans the table memory and moves the last entry on delete.
module uvt_ctrl #(
    parameter int DEPTH = uvt_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [$clog2(DEPTH+1)-1:0]          eff_cap,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [uvt_pkg::CMD_W-1:0]           s_command,
    input  logic signed [uvt_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [uvt_pkg::STATUS_W-1:0]        m_status,
    output logic [uvt_pkg::INDEX_W-1:0]         m_index,
    output logic [uvt_pkg::FILL_W-1:0]          m_fill_count,
    output logic                                ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]            ram_wr_addr,
    output logic [uvt_pkg::VALUE_W-1:0]         ram_wr_data,
    output logic                                ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]            ram_rd_addr,
    input  logic [uvt_pkg::VALUE_W-1:0]         ram_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_RESP
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  ptr_reg, ptr_next;
    logic [AW-1:0]                  hit_reg, hit_next;
    logic [uvt_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic                           del_reg, del_next;
    uvt_pkg::status_t               res_status_reg, res_status_next;
    logic [AW-1:0]                  res_index_reg, res_index_next;
    logic [CW-1:0]                  res_fill_reg, res_fill_next;
    logic                           m_valid_reg, m_valid_next;
    uvt_pkg::status_t               m_status_reg, m_status_next;
    logic [uvt_pkg::INDEX_W-1:0]    m_index_reg, m_index_next;
    logic [uvt_pkg::FILL_W-1:0]     m_fill_reg, m_fill_next;

    logic [AW-1:0]                  last_addr;
    logic                           match;
    logic                           at_last;
    logic [AW+uvt_pkg::INDEX_W-1:0] idx_wide;
    logic [CW+uvt_pkg::FILL_W-1:0]  fill_wide;

    // Slot of the last valid entry and compare of the word being scanned
    assign last_addr = AW'(count_reg - CW'(1));
    assign match     = (ram_rd_data == value_reg);
    assign at_last   = (ptr_reg == last_addr);
    assign idx_wide  = (AW+uvt_pkg::INDEX_W)'(res_index_reg);
    assign fill_wide = (CW+uvt_pkg::FILL_W)'(res_fill_reg);

    assign s_ready = (state_reg == S_IDLE);

    // Sequence one command at a time
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        hit_next        = hit_reg;
        value_next      = value_reg;
        del_next        = del_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_fill_next   = res_fill_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_fill_next     = m_fill_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = value_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    value_next      = s_value;
                    del_next        = (uvt_pkg::cmd_t'(s_command) == uvt_pkg::CMD_DELETE);
                    res_index_next  = '0;
                    res_fill_next   = count_reg;
                    state_next      = S_RESP;
                    case (uvt_pkg::cmd_t'(s_command))
                        uvt_pkg::CMD_ADD: begin
                            if (count_reg >= eff_cap) begin
                                res_status_next = uvt_pkg::ST_FULL;
                            end else begin
                                ram_wr_en       = 1'b1;
                                ram_wr_addr     = AW'(count_reg);
                                ram_wr_data     = s_value;
                                count_next      = count_reg + CW'(1);
                                res_status_next = uvt_pkg::ST_OK;
                                res_index_next  = AW'(count_reg);
                                res_fill_next   = count_reg + CW'(1);
                            end
                        end
                        uvt_pkg::CMD_FIND, uvt_pkg::CMD_DELETE: begin
                            if (count_reg == '0) begin
                                res_status_next = uvt_pkg::ST_MISSING;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                ptr_next    = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default: begin
                            res_status_next = uvt_pkg::ST_MISSING;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    if (del_reg && !at_last) begin
                        // Fetch the last entry to fill the hole
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = last_addr;
                        hit_next    = ptr_reg;
                        state_next  = S_MOVE;
                    end else begin
                        if (del_reg) begin
                            count_next = count_reg - CW'(1);
                        end
                        res_status_next = uvt_pkg::ST_OK;
                        res_index_next  = ptr_reg;
                        res_fill_next   = del_reg ? count_reg - CW'(1) : count_reg;
                        state_next      = S_RESP;
                    end
                end else if (at_last) begin
                    res_status_next = uvt_pkg::ST_MISSING;
                    res_index_next  = '0;
                    res_fill_next   = count_reg;
                    state_next      = S_RESP;
                end else begin
                    // Advance to the next slot
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg + AW'(1);
                    ptr_next    = ptr_reg + AW'(1);
                end
            end
            S_MOVE: begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = hit_reg;
                ram_wr_data     = ram_rd_data;
                count_next      = count_reg - CW'(1);
                res_status_next = uvt_pkg::ST_OK;
                res_index_next  = hit_reg;
                res_fill_next   = count_reg - CW'(1);
                state_next      = S_RESP;
            end
            S_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = idx_wide[uvt_pkg::INDEX_W-1:0];
                    m_fill_next   = fill_wide[uvt_pkg::FILL_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, table count, scan and result registers, and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg        <= ptr_next;
        hit_reg        <= hit_next;
        value_reg      <= value_next;
        del_reg        <= del_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_fill_reg   <= res_fill_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_fill_reg     <= m_fill_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_index      = m_index_reg;
    assign m_fill_count = m_fill_reg;

    // The fill count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count above table depth");

    // The scan pointer stays inside the valid entries
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (CW'(ptr_reg) < count_reg))
        else $error("scan pointer beyond fill count");

    // The memory is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("memory read and write overlap");

    // A move always writes below the last entry
    a_move_below_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE) |-> (hit_reg != last_addr))
        else $error("move targets the last entry");

    // The count changes only on an add, a delete hit or a move, so it holds in S_RESP
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP) |=> $stable(count_reg))
        else $error("count changed while a result was pending");

endmodule

>>> rtl/unordered_value_table.sv
// Unordered value table: top level with the capacity register, sequencer and table memory.
//
// Usage:
//   Input channel s_valid/s_ready carries one command per transaction:
//   s_command (add, find, delete) and the 32-bit signed s_value.
//   Result channel m_valid/m_ready returns one transaction per command:
//   m_status (ok, full, not found), m_index and m_fill_count.
//   cfg_we/cfg_wdata write the capacity register (limit on slots in use,
//   clipped to DEPTH); write it only while no command is in flight.
//   Sequence: an add, a rejected add or a command on an empty table
//   passes through S_RESP to the result register. Find and delete scan
//   the table memory one entry per cycle: a hit ends the scan, and a
//   delete hit below the last slot first moves the last entry into the
//   hole; a miss reads every entry. The single read port of the table
//   memory sets this rate. One command is processed at a time; the next
//   is accepted the cycle after the result register loads, even while
//   that result still waits.
//   When the receiver stalls, the next finished result is held and s_ready
//   stays low until the output register frees.
//   Reset empties the table and sets capacity to 64, with no clearing pass.
module unordered_value_table #(
    parameter int DEPTH = uvt_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [uvt_pkg::CAP_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [uvt_pkg::CMD_W-1:0]           s_command,
    input  logic signed [uvt_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [uvt_pkg::STATUS_W-1:0]        m_status,
    output logic [uvt_pkg::INDEX_W-1:0]         m_index,
    output logic [uvt_pkg::FILL_W-1:0]          m_fill_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH+1);
    localparam int CMPW = (CW > uvt_pkg::CAP_W) ? CW : uvt_pkg::CAP_W;

    logic [uvt_pkg::CAP_W-1:0]   capacity_reg;
    logic [CMPW-1:0]             cap_wide;
    logic [CMPW-1:0]             cap_clip;
    logic [CW-1:0]               eff_cap;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [uvt_pkg::VALUE_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [uvt_pkg::VALUE_W-1:0] ram_rd_data;

    // Hold the capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= uvt_pkg::CAP_RESET;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Clip capacity to the table depth
    assign cap_wide = CMPW'(capacity_reg);
    assign cap_clip = (cap_wide > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_wide;
    assign eff_cap  = cap_clip[CW-1:0];

    uvt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .eff_cap      (eff_cap),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_index      (m_index),
        .m_fill_count (m_fill_count),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    uvt_ram #(
        .WIDTH (uvt_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule
